// ===== rtl/crawl_gait_joint_target_generator_assert.svh =====
// Assertion macros for the crawl gait joint target generator.
`ifndef CRAWL_GAIT_JOINT_TARGET_GENERATOR_ASSERT_SVH
`define CRAWL_GAIT_JOINT_TARGET_GENERATOR_ASSERT_SVH

// same-cycle implication
`define CGJT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define CGJT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/cgjt_pkg.sv =====
// Types, constants, tables and helpers of the crawl gait joint target generator.
package cgjt_pkg;

    localparam int JOINTS      = 12;
    localparam int LEGS        = 4;
    localparam int BLEND_TICKS = 1500;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = 60;

    localparam logic [32:0] BLEND_RECIP = 33'((64'd1 << 32) / BLEND_TICKS);

    localparam logic [16:0] ONE_Q15    = 17'd32768;
    localparam logic [21:0] TICK_MAX   = 22'h3FFFFF;
    localparam logic [31:0] LEG_OFFSET = 32'h6000_0000;

    localparam logic signed [23:0] DEADBAND   = 24'sd20972;
    localparam logic signed [19:0] CORR_LIMIT = 20'sd1229;
    localparam logic signed [19:0] THIGH_LO   = 20'sd6144;
    localparam logic signed [19:0] THIGH_HI   = 20'sd10650;
    localparam logic signed [19:0] CALF_LO    = -20'sd19251;
    localparam logic signed [19:0] CALF_HI    = -20'sd14336;
    localparam logic signed [19:0] HIP_LO     = -20'sd32768;
    localparam logic signed [19:0] HIP_HI     = 20'sd32767;
    localparam logic [15:0] KP_LO = 16'd7680;
    localparam logic [15:0] KP_HI = 16'd20480;
    localparam logic [15:0] KD_LO = 16'd768;
    localparam logic [15:0] KD_HI = 16'd2048;

    localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] CFG_STRIDE       = 3'd1;
    localparam logic [2:0] CFG_LIFT         = 3'd2;
    localparam logic [2:0] CFG_BALANCE_GAIN = 3'd3;
    localparam logic [2:0] CFG_KP_START     = 3'd4;
    localparam logic [2:0] CFG_KD_START     = 3'd5;
    localparam logic [2:0] CFG_CRAWL_TICKS  = 3'd6;
    localparam logic [2:0] CFG_CONTACT_THR  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILT, ST_SEL, ST_DIV, ST_BLEND, ST_CRAWL, ST_TILT, ST_FINAL, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {MODE_RISE, MODE_CRAWL, MODE_FALL} mode_t;

    localparam logic signed [16:0] CRAWL_POSE [JOINTS] = '{
        17'sd983, 17'sd8602, -17'sd16794, -17'sd983, 17'sd8602, -17'sd16794,
        17'sd983, 17'sd8602, -17'sd16794, -17'sd983, 17'sd8602, -17'sd16794
    };
    localparam logic signed [16:0] LYING_POSE [JOINTS] = '{
        17'sd410, 17'sd9421, -17'sd18432, -17'sd410, 17'sd9421, -17'sd18432,
        17'sd410, 17'sd9421, -17'sd18432, -17'sd410, 17'sd9421, -17'sd18432
    };
    localparam logic signed [16:0] TANH_TAB [25] = '{
        17'sd0, 17'sd8026, 17'sd15143, 17'sd20813, 17'sd24956, 17'sd27797, 17'sd29660,
        17'sd30847, 17'sd31590, 17'sd32048, 17'sd32330, 17'sd32501, 17'sd32606,
        17'sd32670, 17'sd32708, 17'sd32732, 17'sd32746, 17'sd32755, 17'sd32760,
        17'sd32763, 17'sd32765, 17'sd32766, 17'sd32767, 17'sd32767, 17'sd32768
    };
    localparam logic signed [16:0] COS_TAB [17] = '{
        17'sd32768, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
        17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
        17'sd12540, 17'sd9512, 17'sd6393, 17'sd3212, 17'sd0
    };

    // right shift, rounding half away from zero
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [19:0] clamp20(input logic signed [19:0] v,
                                                    input logic signed [19:0] lo,
                                                    input logic signed [19:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

endpackage

// ===== rtl/cgjt_mul.sv =====
// Shared signed multiplier with registered product.
module cgjt_mul (
    input  logic                                  aclk,
    input  logic signed [cgjt_pkg::MUL_A_W-1:0]   a,
    input  logic signed [cgjt_pkg::MUL_B_W-1:0]   b,
    output logic signed [cgjt_pkg::MUL_P_W-1:0]   p
);
    import cgjt_pkg::*;

    always_ff @(posedge aclk) begin
        p <= MUL_P_W'(a) * MUL_P_W'(b);
    end

endmodule

// ===== rtl/crawl_gait_joint_target_generator.sv =====
// Top level: sequencer around one shared multiplier producing twelve joint targets per tick.
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    kind, roll, pitch, four foot forces
//  m_       out  m_valid / m_ready    joint, target_angle, stiffness, damping, last
//  cfg_     in   cfg_wr_en            cfg_addr, cfg_wr_data
//
// Sensor request: two filter products, roll then pitch; s_ready is low until both are done.
// Tick request: a blend tick divides and looks up the tanh weight (skipped once the fall
// weight is full), then blends twelve joints; a crawl tick works four legs, then tilt, then
// limit; twelve results follow. All steps share the one multiplier. For a tick, s_ready stays
// low from acceptance until the last result is taken; m_ready low holds the current result.
// Reset (aresetn, synchronous) loads register defaults and clears state; no clearing pass.
module crawl_gait_joint_target_generator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [15:0] s_roll,
    input  logic signed [15:0] s_pitch,
    input  logic signed [15:0] s_force_front_right,
    input  logic signed [15:0] s_force_front_left,
    input  logic signed [15:0] s_force_rear_right,
    input  logic signed [15:0] s_force_rear_left,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_joint,
    output logic signed [15:0] m_target_angle,
    output logic [15:0]        m_stiffness,
    output logic [15:0]        m_damping,
    output logic               m_last,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [23:0]        cfg_wr_data
);
    import cgjt_pkg::*;

    state_t st_reg, st_next;
    mode_t  mode_reg, mode_next;
    logic [3:0]  sub_reg, sub_next;
    logic [1:0]  leg_reg, leg_next;
    logic [1:0]  role_reg, role_next;
    logic [3:0]  jnt_reg, jnt_next;
    logic [2:0]  sup_reg, sup_next;

    logic [23:0] step_reg, step_next;
    logic [12:0] stride_reg, stride_next;
    logic [12:0] lift_reg, lift_next;
    logic [14:0] bg_reg, bg_next;
    logic [15:0] kps_reg, kps_next;
    logic [15:0] kds_reg, kds_next;
    logic [19:0] crawl_reg, crawl_next;
    logic [14:0] thr_reg, thr_next;

    logic [21:0] tick_reg, tick_next;
    logic [31:0] phase_reg, phase_next;
    logic signed [23:0] rf_reg, rf_next, pf_reg, pf_next;
    logic [3:0]  contact_reg, contact_next;
    logic [15:0] kp_reg, kp_next, kd_reg, kd_next;
    logic        done_reg, done_next;

    logic signed [15:0] roll_in_reg, roll_in_next, pitch_in_reg, pitch_in_next;
    logic [24:0] x_reg, x_next;
    logic [19:0] pos_reg, pos_next;
    logic [4:0]  tidx_reg, tidx_next;
    logic [16:0] w_reg, w_next;
    logic [15:0] sw_reg, sw_next;
    logic signed [17:0] adj_reg, adj_next;
    logic signed [17:0] a3r_reg, a3r_next, a2r_reg, a2r_next;
    logic signed [17:0] a3p_reg, a3p_next, a2p_reg, a2p_next;
    logic signed [17:0] tgt_reg [JOINTS];
    logic signed [17:0] tgt_next [JOINTS];

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [25:0] fd_roll, fd_pitch;
    logic signed [63:0] fsum;
    logic signed [23:0] fres;
    logic [21:0] end_sum, mcnt;
    logic [19:0] q0, qv;
    logic [27:0] rem;
    logic [4:0]  pidx;
    logic [31:0] lp;
    logic [1:0]  quad;
    logic [30:0] xq;
    logic [4:0]  cidx;
    logic signed [17:0] cbase, cq;
    logic signed [18:0] cv, swv;
    logic [3:0]  jb, jb3;
    logic [3:0]  kk;
    logic        axis, db;
    logic signed [23:0] fsel;
    logic signed [19:0] corr, tsum, tcl;
    logic signed [17:0] kpv, kdv;
    logic signed [63:0] bv;
    logic signed [16:0] pdiff;

    cgjt_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    always_comb begin
        fd_roll  = (26'(roll_in_reg) <<< 8) - 26'(rf_reg);
        fd_pitch = (26'(pitch_in_reg) <<< 8) - 26'(pf_reg);
        fsum = ((sub_reg == 4'd1) ? 64'(rf_reg) : 64'(pf_reg)) + rshr(64'(mul_p), 16);
        fres = (fsum > 64'sd8388607) ? 24'sh7FFFFF :
               ((fsum < -64'sd8388608) ? 24'sh800000 : fsum[23:0]);

        end_sum = 22'(BLEND_TICKS) + 22'(crawl_reg);
        mcnt    = (tick_reg > end_sum) ? (tick_reg - end_sum) : 22'd0;

        q0   = mul_p[51:32];
        rem  = 28'(x_reg) - 28'(q0 * BLEND_TICKS);
        qv   = (rem >= 28'(BLEND_TICKS)) ? 20'(q0 + 20'd1) : q0;
        pidx = pos_reg[12:8];

        lp    = phase_reg + (((leg_reg == 2'd1) || (leg_reg == 2'd2)) ? LEG_OFFSET : 32'd0);
        quad  = lp[31:30];
        xq    = quad[0] ? (31'h4000_0000 - {1'b0, lp[29:0]}) : {1'b0, lp[29:0]};
        cidx  = xq[30:26];
        cbase = (cidx < 5'd16) ? 18'(COS_TAB[cidx]) : 18'sd0;
        cq    = cbase - 18'((mul_p + 60'sd32768) >>> 16);
        cv    = ((quad == 2'd1) || (quad == 2'd2)) ? -19'(cq) : 19'(cq);
        swv   = lp[31] ? ((19'sd65536 + cv + 19'sd1) >>> 1) : ((19'sd32768 - cv + 19'sd1) >>> 1);
        jb3   = 4'({leg_reg, 1'b0}) + 4'(leg_reg);
        jb    = 4'(sub_reg - 4'd1);

        axis = (sub_reg >= 4'd5);
        kk   = axis ? 4'(sub_reg - 4'd5) : sub_reg;
        fsel = axis ? pf_reg : rf_reg;
        db   = (fsel > DEADBAND) || (fsel < -DEADBAND);

        priority if (role_reg == 2'd1) begin
            corr = (leg_reg[0] ? 20'(a3r_reg) : -20'(a3r_reg))
                 + (leg_reg[1] ? 20'(a3p_reg) : -20'(a3p_reg))
                 - (contact_reg[leg_reg] ? 20'sd0 : 20'sd123);
        end else if (role_reg == 2'd2) begin
            corr = (leg_reg[0] ? -20'(a2r_reg) : 20'(a2r_reg))
                 + (leg_reg[1] ? -20'(a2p_reg) : 20'(a2p_reg))
                 + (contact_reg[leg_reg] ? 20'sd0 : 20'sd82);
        end else begin
            corr = 20'sd0;
        end
        tsum = 20'(tgt_reg[jnt_reg]) + clamp20(corr, -CORR_LIMIT, CORR_LIMIT);
        priority if (role_reg == 2'd1) tcl = clamp20(tsum, THIGH_LO, THIGH_HI);
        else if (role_reg == 2'd2)     tcl = clamp20(tsum, CALF_LO, CALF_HI);
        else                           tcl = clamp20(tsum, HIP_LO, HIP_HI);

        kpv = 18'(kp_reg) + ((sup_reg < 3'd3) ? 18'sd1280 : ((sup_reg == 3'd4) ? -18'sd512 : 18'sd0));
        kdv = 18'(kd_reg) + ((sup_reg < 3'd3) ? 18'sd128 : ((sup_reg == 3'd4) ? -18'sd51 : 18'sd0));

        pdiff = (mode_reg == MODE_RISE) ? 17'(CRAWL_POSE[sub_reg] - LYING_POSE[sub_reg])
                                        : 17'(LYING_POSE[sub_reg] - CRAWL_POSE[sub_reg]);
        bv = (((mode_reg == MODE_RISE) ? 64'(LYING_POSE[jb]) : 64'(CRAWL_POSE[jb])) <<< 15)
           + 64'(mul_p);
    end

    always_comb begin
        st_next = st_reg;   mode_next = mode_reg; sub_next = sub_reg;
        leg_next = leg_reg; role_next = role_reg; jnt_next = jnt_reg; sup_next = sup_reg;
        step_next = step_reg; stride_next = stride_reg; lift_next = lift_reg;
        bg_next = bg_reg; kps_next = kps_reg; kds_next = kds_reg;
        crawl_next = crawl_reg; thr_next = thr_reg;
        tick_next = tick_reg; phase_next = phase_reg; rf_next = rf_reg; pf_next = pf_reg;
        contact_next = contact_reg; kp_next = kp_reg; kd_next = kd_reg; done_next = done_reg;
        roll_in_next = roll_in_reg; pitch_in_next = pitch_in_reg;
        x_next = x_reg; pos_next = pos_reg; tidx_next = tidx_reg; w_next = w_reg;
        sw_next = sw_reg; adj_next = adj_reg;
        a3r_next = a3r_reg; a2r_next = a2r_reg; a3p_next = a3p_reg; a2p_next = a2p_reg;
        tgt_next = tgt_reg;
        mul_a = '0;
        mul_b = '0;
        s_ready = (st_reg == ST_IDLE);
        m_valid = (st_reg == ST_EMIT);

        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_kind) begin
                        roll_in_next  = s_roll;
                        pitch_in_next = s_pitch;
                        contact_next  = {
                            (17'(s_force_rear_left)   > $signed({2'b0, thr_reg})),
                            (17'(s_force_rear_right)  > $signed({2'b0, thr_reg})),
                            (17'(s_force_front_left)  > $signed({2'b0, thr_reg})),
                            (17'(s_force_front_right) > $signed({2'b0, thr_reg}))};
                        sub_next = 4'd0;
                        st_next  = ST_FILT;
                    end else begin
                        if (tick_reg < TICK_MAX) tick_next = tick_reg + 22'd1;
                        phase_next = phase_reg + {8'd0, step_reg};
                        st_next    = ST_SEL;
                    end
                end
            end
            ST_FILT: begin
                priority if (sub_reg == 4'd0) begin
                    mul_a = 33'(fd_roll);
                    mul_b = 27'sd3277;
                    sub_next = 4'd1;
                end else if (sub_reg == 4'd1) begin
                    rf_next = fres;
                    mul_a = 33'(fd_pitch);
                    mul_b = 27'sd3277;
                    sub_next = 4'd2;
                end else begin
                    pf_next = fres;
                    st_next = ST_IDLE;
                end
            end
            ST_SEL: begin
                sub_next = 4'd0;
                priority if (tick_reg < 22'(BLEND_TICKS)) begin
                    mode_next = MODE_RISE;
                    x_next    = 25'(tick_reg) << 11;
                    st_next   = ST_DIV;
                end else if (!done_reg) begin
                    mode_next = MODE_CRAWL;
                    leg_next  = 2'd0;
                    sup_next  = 3'd0;
                    st_next   = ST_CRAWL;
                end else begin
                    mode_next = MODE_FALL;
                    if (mcnt >= 22'(2 * BLEND_TICKS)) begin
                        w_next  = ONE_Q15;
                        st_next = ST_BLEND;
                    end else begin
                        x_next  = 25'(mcnt) * 25'd3072;
                        st_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                priority if (sub_reg == 4'd0) begin
                    mul_a = BLEND_RECIP;
                    mul_b = 27'(x_reg);
                    sub_next = 4'd1;
                end else if (sub_reg == 4'd1) begin
                    pos_next = qv;
                    sub_next = 4'd2;
                end else if (sub_reg == 4'd2) begin
                    if (pos_reg[19:8] >= 12'd24) begin
                        w_next   = ONE_Q15;
                        sub_next = 4'd0;
                        st_next  = ST_BLEND;
                    end else begin
                        tidx_next = pidx;
                        mul_a = 33'(TANH_TAB[5'(pidx + 5'd1)] - TANH_TAB[pidx]);
                        mul_b = 27'({19'd0, pos_reg[7:0]});
                        sub_next = 4'd3;
                    end
                end else begin
                    w_next   = 17'(TANH_TAB[tidx_reg]) + 17'((mul_p + 60'sd128) >>> 8);
                    sub_next = 4'd0;
                    st_next  = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (sub_reg < 4'd12) begin
                    mul_a = 33'(w_reg);
                    mul_b = 27'(pdiff);
                end
                if (sub_reg > 4'd0) tgt_next[jb] = 18'(rshr(bv, 15));
                if (sub_reg == 4'd12) begin
                    jnt_next = 4'd0;
                    st_next  = ST_EMIT;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_CRAWL: begin
                priority if (sub_reg == 4'd0) begin
                    if (cidx < 5'd16) begin
                        mul_a = 33'(COS_TAB[cidx] - COS_TAB[5'(cidx + 5'd1)]);
                        mul_b = 27'({11'd0, xq[25:10]});
                    end
                    sub_next = 4'd1;
                end else if (sub_reg == 4'd1) begin
                    sw_next = swv[15:0];
                    if (quad == 2'd0) sup_next = sup_reg + 3'd1;
                    sub_next = 4'd2;
                end else if (sub_reg == 4'd2) begin
                    mul_a = 33'(stride_reg);
                    mul_b = 27'({11'd0, sw_reg}) - 27'sd16384;
                    sub_next = 4'd3;
                end else if (sub_reg == 4'd3) begin
                    tgt_next[jb3] = 18'(CRAWL_POSE[jb3]) + 18'(rshr(64'(mul_p), 15));
                    mul_a = 33'(lift_reg);
                    mul_b = 27'({11'd0, sw_reg});
                    sub_next = 4'd4;
                end else if (sub_reg == 4'd4) begin
                    tgt_next[4'(jb3 + 4'd1)] = 18'(CRAWL_POSE[4'(jb3 + 4'd1)])
                                             + 18'(rshr(64'(mul_p), 15));
                    mul_a = mul_p[32:0];
                    mul_b = 27'sd13107;
                    sub_next = 4'd5;
                end else begin
                    tgt_next[4'(jb3 + 4'd2)] = 18'(CRAWL_POSE[4'(jb3 + 4'd2)])
                                             - 18'(rshr(64'(mul_p), 30));
                    sub_next = 4'd0;
                    if (leg_reg == 2'd3) st_next = ST_TILT;
                    else leg_next = leg_reg + 2'd1;
                end
            end
            ST_TILT: begin
                priority if (kk == 4'd0) begin
                    mul_a = 33'(fsel);
                    mul_b = 27'({12'd0, bg_reg});
                end else if (kk == 4'd1) begin
                    adj_next = 18'(rshr(64'(mul_p), 21));
                end else if (kk == 4'd2) begin
                    mul_a = 33'(adj_reg);
                    mul_b = 27'sd9830;
                end else if (kk == 4'd3) begin
                    if (axis) a3p_next = db ? 18'(rshr(64'(mul_p), 15)) : 18'sd0;
                    else      a3r_next = db ? 18'(rshr(64'(mul_p), 15)) : 18'sd0;
                    mul_a = 33'(adj_reg);
                    mul_b = 27'sd6554;
                end else begin
                    if (axis) a2p_next = db ? 18'(rshr(64'(mul_p), 15)) : 18'sd0;
                    else      a2r_next = db ? 18'(rshr(64'(mul_p), 15)) : 18'sd0;
                end
                if (sub_reg == 4'd9) begin
                    jnt_next  = 4'd0;
                    leg_next  = 2'd0;
                    role_next = 2'd0;
                    st_next   = ST_FINAL;
                end else begin
                    sub_next = sub_reg + 4'd1;
                end
            end
            ST_FINAL: begin
                tgt_next[jnt_reg] = 18'(tcl);
                if (jnt_reg == 4'd0) begin
                    kp_next = (kpv < $signed(18'(KP_LO))) ? KP_LO :
                              ((kpv > $signed(18'(KP_HI))) ? KP_HI : kpv[15:0]);
                    kd_next = (kdv < $signed(18'(KD_LO))) ? KD_LO :
                              ((kdv > $signed(18'(KD_HI))) ? KD_HI : kdv[15:0]);
                end
                if (role_reg == 2'd2) begin
                    role_next = 2'd0;
                    leg_next  = leg_reg + 2'd1;
                end else begin
                    role_next = role_reg + 2'd1;
                end
                if (jnt_reg == 4'(JOINTS - 1)) begin
                    if (tick_reg >= end_sum) done_next = 1'b1;
                    jnt_next = 4'd0;
                    st_next  = ST_EMIT;
                end else begin
                    jnt_next = jnt_reg + 4'd1;
                end
            end
            ST_EMIT: begin
                if (m_ready) begin
                    if (jnt_reg == 4'(JOINTS - 1)) st_next = ST_IDLE;
                    else jnt_next = jnt_reg + 4'd1;
                end
            end
            default: st_next = ST_IDLE;
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_PHASE_STEP:   step_next   = cfg_wr_data;
                CFG_STRIDE:       stride_next = cfg_wr_data[12:0];
                CFG_LIFT:         lift_next   = cfg_wr_data[12:0];
                CFG_BALANCE_GAIN: bg_next     = cfg_wr_data[14:0];
                CFG_KP_START: begin
                    kps_next = cfg_wr_data[15:0];
                    kp_next  = cfg_wr_data[15:0];
                end
                CFG_KD_START: begin
                    kds_next = cfg_wr_data[15:0];
                    kd_next  = cfg_wr_data[15:0];
                end
                CFG_CRAWL_TICKS:  crawl_next  = cfg_wr_data[19:0];
                CFG_CONTACT_THR:  thr_next    = cfg_wr_data[14:0];
            endcase
        end
    end

    assign m_joint        = jnt_reg;
    assign m_target_angle = tgt_reg[jnt_reg][15:0];
    assign m_stiffness    = (kp_reg < KP_LO) ? KP_LO : ((kp_reg > KP_HI) ? KP_HI : kp_reg);
    assign m_damping      = (kd_reg < KD_LO) ? KD_LO : ((kd_reg > KD_HI) ? KD_HI : kd_reg);
    assign m_last         = (jnt_reg == 4'(JOINTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            mode_reg    <= MODE_RISE;
            sub_reg     <= 4'd0;
            leg_reg     <= 2'd0;
            role_reg    <= 2'd0;
            jnt_reg     <= 4'd0;
            sup_reg     <= 3'd0;
            step_reg    <= 24'd2576980;
            stride_reg  <= 13'd328;
            lift_reg    <= 13'd164;
            bg_reg      <= 15'd6554;
            kps_reg     <= 16'd14080;
            kds_reg     <= 16'd1408;
            crawl_reg   <= 20'd30000;
            thr_reg     <= 15'd5;
            tick_reg    <= 22'd0;
            phase_reg   <= 32'd0;
            rf_reg      <= 24'sd0;
            pf_reg      <= 24'sd0;
            contact_reg <= 4'hF;
            kp_reg      <= 16'd14080;
            kd_reg      <= 16'd1408;
            done_reg    <= 1'b0;
        end else begin
            st_reg      <= st_next;
            mode_reg    <= mode_next;
            sub_reg     <= sub_next;
            leg_reg     <= leg_next;
            role_reg    <= role_next;
            jnt_reg     <= jnt_next;
            sup_reg     <= sup_next;
            step_reg    <= step_next;
            stride_reg  <= stride_next;
            lift_reg    <= lift_next;
            bg_reg      <= bg_next;
            kps_reg     <= kps_next;
            kds_reg     <= kds_next;
            crawl_reg   <= crawl_next;
            thr_reg     <= thr_next;
            tick_reg    <= tick_next;
            phase_reg   <= phase_next;
            rf_reg      <= rf_next;
            pf_reg      <= pf_next;
            contact_reg <= contact_next;
            kp_reg      <= kp_next;
            kd_reg      <= kd_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        roll_in_reg  <= roll_in_next;
        pitch_in_reg <= pitch_in_next;
        x_reg        <= x_next;
        pos_reg      <= pos_next;
        tidx_reg     <= tidx_next;
        w_reg        <= w_next;
        sw_reg       <= sw_next;
        adj_reg      <= adj_next;
        a3r_reg      <= a3r_next;
        a2r_reg      <= a2r_next;
        a3p_reg      <= a3p_next;
        a2p_reg      <= a2p_next;
        tgt_reg      <= tgt_next;
    end

`include "crawl_gait_joint_target_generator_assert.svh"

    `CGJT_ASSERT_NOW(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    `CGJT_ASSERT_NEXT(a_last_idle, aclk, aresetn, m_valid && m_ready && m_last, s_ready)
    `CGJT_ASSERT_NOW(a_gain_range, aclk, aresetn, m_valid && mode_reg == MODE_CRAWL, kp_reg >= KP_LO && kp_reg <= KP_HI && kd_reg >= KD_LO && kd_reg <= KD_HI)
    `CGJT_ASSERT_NEXT(a_tick_sel, aclk, aresetn, s_valid && s_ready && s_kind, st_reg == ST_SEL)

endmodule
